### src/adcts_pkg.sv
// ----------------------------------------------------------------------------
// adcts_pkg: shared types and constants
// Widths, Q16 conversion constants, scan positions and the segment decoder
// for the ADC temperature seven-segment display block.
// ----------------------------------------------------------------------------
package adcts_pkg;

	// converter and display shape
	localparam int ADC_BITS   = 12;
	localparam int NUM_DIGITS = 3;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int TEMP_W   = 13;
	localparam int SEG_W    = 7;
	localparam int EN_W     = 3;
	localparam int TPD_W    = 16;
	localparam int SCAN_W   = 2;
	localparam int DIG_W    = 4;

	// stream data widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_RAW_W   = SEG_W + EN_W + TEMP_W;
	localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	// t = K_OFFSET - K_SLOPE * sample, both Q16
	localparam int SLOPE_W  = 19;
	localparam int OFFSET_W = 29;
	localparam int Q_SHIFT  = 16;
	localparam logic [SLOPE_W-1:0]  K_SLOPE  = 19'd306798;
	localparam logic [OFFSET_W-1:0] K_OFFSET = 29'd286540833;
	localparam int PROD_W = SLOPE_W + SAMPLE_W;
	localparam int CALC_W = (PROD_W > OFFSET_W) ? PROD_W : OFFSET_W;

	// display holds the value modulo 1000
	localparam int TEMP_MOD  = 1000;
	localparam int REM_W     = 10;
	localparam int MOD_STEPS = ((1 << TEMP_W) - 1) / TEMP_MOD;

	// scan positions
	localparam logic [SCAN_W-1:0] POS_TENTHS = 2'd0;
	localparam logic [SCAN_W-1:0] POS_UNITS  = 2'd1;
	localparam logic [SCAN_W-1:0] POS_TENS   = 2'd2;

	// blank pattern for codes that are not a decimal digit
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

	// three decimal digits of the displayed value
	typedef struct packed {
		logic [DIG_W-1:0] d2;	// tens
		logic [DIG_W-1:0] d1;	// units
		logic [DIG_W-1:0] d0;	// tenths
	} digits_t;

	// common-anode decoder, segments A..G on bits 0..6, active low
	function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 7'h40;
			4'd1: s = 7'h79;
			4'd2: s = 7'h24;
			4'd3: s = 7'h30;
			4'd4: s = 7'h19;
			4'd5: s = 7'h12;
			4'd6: s = 7'h02;
			4'd7: s = 7'h78;
			4'd8: s = 7'h00;
			4'd9: s = 7'h18;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

### src/adcts_conv.sv
// ----------------------------------------------------------------------------
// adcts_conv: ADC sample to tenths of a degree
// One constant multiply and subtract in Q16; negative results clamp to zero,
// positive ones truncate toward zero.
// ----------------------------------------------------------------------------
module adcts_conv
	import adcts_pkg::*;
(
	input  logic [SAMPLE_W-1:0] sample,
	output logic [TEMP_W-1:0]   temp
);

	localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

	logic [SAMPLE_W-1:0] smp_m;
	logic [CALC_W-1:0]   prod;
	logic [CALC_W-1:0]   diff;

	// only the converter's bits take part
	assign smp_m = sample & ADC_MASK;

	// slope times sample, then offset minus product
	assign prod = CALC_W'(K_SLOPE) * CALC_W'(smp_m);
	assign diff = CALC_W'(K_OFFSET) - prod;

	// clamp at zero, drop the Q16 fraction
	always_comb begin
		if (prod >= CALC_W'(K_OFFSET)) begin
			temp = '0;
		end else begin
			temp = diff[Q_SHIFT +: TEMP_W];
		end
	end

endmodule

### src/adcts_digits.sv
// ----------------------------------------------------------------------------
// adcts_digits: decimal digits of the displayed temperature
// Reduces the value modulo 1000 by parallel compares, then splits it with
// reciprocal multiplies by 10 and 100.
// ----------------------------------------------------------------------------
module adcts_digits
	import adcts_pkg::*;
(
	input  logic [TEMP_W-1:0] temp,
	output digits_t           digits
);

	// x/10 = (x*205)>>11 and x/100 = (x*41)>>12, exact for x < 1000
	localparam int P10_W   = 18;
	localparam int P100_W  = 16;
	localparam int SH10    = 11;
	localparam int SH100   = 12;
	localparam int Q10_W   = 7;
	localparam logic [P10_W-1:0]  MUL10  = 18'd205;
	localparam logic [P100_W-1:0] MUL100 = 16'd41;

	logic [TEMP_W-1:0] rem_full;
	logic [REM_W-1:0]  rem;
	logic [P10_W-1:0]  p10;
	logic [P100_W-1:0] p100;
	logic [Q10_W-1:0]  q10;
	logic [DIG_W-1:0]  q100;

	// modulo 1000: largest multiple not above the value wins
	always_comb begin
		rem_full = temp;
		for (int k = 1; k <= MOD_STEPS; k++) begin
			if (temp >= TEMP_W'(k * TEMP_MOD)) begin
				rem_full = temp - TEMP_W'(k * TEMP_MOD);
			end
		end
	end
	assign rem = rem_full[REM_W-1:0];

	// quotients by 10 and 100
	assign p10  = P10_W'(rem) * MUL10;
	assign p100 = P100_W'(rem) * MUL100;
	assign q10  = p10[SH10 +: Q10_W];
	assign q100 = p100[SH100 +: DIG_W];

	// remainders give the lower digits
	assign digits.d0 = DIG_W'(rem - (REM_W'(q10) * REM_W'(10)));
	assign digits.d1 = DIG_W'(q10 - (Q10_W'(q100) * Q10_W'(10)));
	assign digits.d2 = q100;

endmodule

### src/adc_temperature_seven_segment_display.sv
// ----------------------------------------------------------------------------
// adc_temperature_seven_segment_display: temperature readout and digit scan
// Converts ADC samples to tenths of a degree and drives a multiplexed
// three-digit common-anode seven-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis: tuser = 1 carries a new ADC sample in tdata,
//   tuser = 0 is a time tick that advances the digit scan after
//   ticks_per_digit ticks (0 acts as 1). Every input beat yields exactly one
//   output beat on m_axis with the active-low segments of the lit digit,
//   its one-hot enable and the stored temperature.
//   cfg_we/cfg_wdata load ticks_per_digit; write only while no beat is in
//   flight.
// Timing:
//   A beat goes from the input register through the conversion multiply
//   into a register, through the digit split into a further register, then
//   through the state update into the output register.
//   Throughput is one beat per cycle; the pipeline stages each hold a beat,
//   so the input keeps accepting while bubbles remain.
// Reset:
//   arst_n clears the temperature, scan position (tenths digit) and dwell
//   count, and sets ticks_per_digit to 4. No beats are held after reset.
// Stall:
//   When m_axis_tready is low the output beat holds and the stages fill
//   up; s_axis_tready drops once every stage holds a beat.
// ----------------------------------------------------------------------------
module adc_temperature_seven_segment_display
	import adcts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: ticks_per_digit
	input  logic                   cfg_we,
	input  logic [TPD_W-1:0]       cfg_wdata,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,	// [11:0] sample
	input  logic                   s_axis_tuser,	// [0] command
	// output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata	// [6:0] segments, [9:7] digit_enable,
							// [22:10] temperature_tenths
);

	// pipeline valid and payload
	logic                v_s1, v_s2, v_s3;
	logic                cmd_s1, cmd_s2, cmd_s3;
	logic [SAMPLE_W-1:0] smp_s1;
	logic [TEMP_W-1:0]   temp_s2, temp_s3;
	digits_t             dig_s3;

	// block state
	logic [TPD_W-1:0]  tpd_q;
	logic [TEMP_W-1:0] temp_q;
	digits_t           dig_q;
	logic [SCAN_W-1:0] scan_q;
	logic [TPD_W-1:0]  dwell_q;

	// handshake
	logic rdy_out, rdy3, rdy2, rdy1, adv3;

	// datapath
	logic [TEMP_W-1:0] conv_temp;
	digits_t           split_dig;

	// stage C next values
	logic [TPD_W-1:0]    limit;
	logic [TPD_W:0]      dwell_inc;
	logic                wrap;
	logic [SCAN_W:0]     scan_inc;
	logic [SCAN_W-1:0]   scan_adv;
	logic [TEMP_W-1:0]   temp_n;
	digits_t             dig_n;
	logic [SCAN_W-1:0]   scan_n;
	logic [TPD_W-1:0]    dwell_n;
	logic [DIG_W-1:0]    lit_dig;
	logic [EN_W:0]       en_full;
	logic [SEG_W-1:0]    seg_n;
	logic [EN_W-1:0]     en_n;

	// ready ripples back through stages that hold a beat
	assign rdy_out       = !m_axis_tvalid || m_axis_tready;
	assign rdy3          = !v_s3 || rdy_out;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign adv3          = v_s3 && rdy_out;
	assign s_axis_tready = rdy1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpd_q <= TPD_W'(4);
		end else if (cfg_we) begin
			tpd_q <= cfg_wdata;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy_out) m_axis_tvalid <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			cmd_s1 <= s_axis_tuser;
			smp_s1 <= s_axis_tdata[SAMPLE_W-1:0];
		end
	end

	// stage A: sample conversion
	adcts_conv u_conv (
		.sample (smp_s1),
		.temp   (conv_temp)
	);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			cmd_s2  <= cmd_s1;
			temp_s2 <= conv_temp;
		end
	end

	// stage B: decimal digits
	adcts_digits u_digits (
		.temp   (temp_s2),
		.digits (split_dig)
	);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			cmd_s3  <= cmd_s2;
			temp_s3 <= temp_s2;
			dig_s3  <= split_dig;
		end
	end

	// stage C: dwell counter and scan step
	assign limit     = (tpd_q == '0) ? TPD_W'(1) : tpd_q;
	assign dwell_inc = {1'b0, dwell_q} + (TPD_W+1)'(1);
	assign wrap      = dwell_inc >= {1'b0, limit};
	assign scan_inc  = {1'b0, scan_q} + (SCAN_W+1)'(1);
	assign scan_adv  = (scan_inc >= (SCAN_W+1)'(NUM_DIGITS)) ? POS_TENTHS
		: scan_inc[SCAN_W-1:0];

	// sample beats load the temperature, ticks move the scan
	always_comb begin
		temp_n  = temp_q;
		dig_n   = dig_q;
		scan_n  = scan_q;
		dwell_n = dwell_q;
		if (cmd_s3) begin
			temp_n = temp_s3;
			dig_n  = dig_s3;
		end else if (wrap) begin
			scan_n  = scan_adv;
			dwell_n = '0;
		end else begin
			dwell_n = dwell_inc[TPD_W-1:0];
		end
	end

	// digit under the scan; a thousands position would show zero
	always_comb begin
		case (scan_n)
			POS_TENTHS: lit_dig = dig_n.d0;
			POS_UNITS:  lit_dig = dig_n.d1;
			POS_TENS:   lit_dig = dig_n.d2;
			default:    lit_dig = '0;
		endcase
	end

	assign seg_n   = seg_of(lit_dig);
	assign en_full = (EN_W+1)'(1) << scan_n;
	assign en_n    = en_full[EN_W-1:0];

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			dig_q   <= '0;
			scan_q  <= POS_TENTHS;
			dwell_q <= '0;
		end else if (adv3) begin
			temp_q  <= temp_n;
			dig_q   <= dig_n;
			scan_q  <= scan_n;
			dwell_q <= dwell_n;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv3) begin
			m_axis_tdata <= OUT_TDATA_W'({temp_n, en_n, seg_n});
		end
	end

	// scan never leaves the populated digits
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q < SCAN_W'(NUM_DIGITS))
		else $error("scan position out of range");

	// stored digits are decimal
	a_dig_dec: assert property (@(posedge clk) disable iff (!arst_n)
		dig_q.d0 <= DIG_W'(9) && dig_q.d1 <= DIG_W'(9) && dig_q.d2 <= DIG_W'(9))
		else $error("stored digit not decimal");

	// a sample beat leaves the scan and dwell alone
	a_sample_keeps_scan: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 && cmd_s3 |=> $stable(scan_q) && $stable(dwell_q))
		else $error("sample beat moved the scan");

	// a tick that ends the dwell restarts the count
	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 && !cmd_s3 && wrap |=> dwell_q == '0)
		else $error("dwell count not cleared on scan step");

	// stored temperature stays within the conversion range
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		temp_q <= TEMP_W'(4372))
		else $error("temperature above conversion range");

endmodule

### tb/adc_display_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_display_checker: prediction and comparison for the temperature display
// Watches the configuration port and both stream channels. Every accepted
// input beat updates a private copy of the stored temperature and the digit
// scan, and queues the display beat it must produce. Each output beat is
// compared field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
module adc_display_checker
	import adcts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [TPD_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,	// [11:0] sample
	input  logic                   s_axis_tuser,	// [0] command
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,	// [6:0] segments, [9:7] digit_enable,
							// [22:10] temperature_tenths
	output int unsigned            mismatches,
	output int unsigned            outstanding
);

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [EN_W-1:0]   enable;
		logic [SEG_W-1:0]  seg;
	} display_beat_t;

	// private copy of the block state and its dwell register
	logic [TPD_W-1:0]  dwell_limit;
	logic [TPD_W-1:0]  dwell_ticks;
	logic [SCAN_W-1:0] lit_pos;
	logic [TEMP_W-1:0] stored_temp;
	display_beat_t     expected_display[$];
	int unsigned       error_count;
	int unsigned       pending;

	assign mismatches  = error_count;
	assign outstanding = pending;

	// tuser high means tdata carries a fresh reading
	wire carries_sample = s_axis_tuser;

	// common-anode pattern, A..G on bits 0..6, low = lit
	function automatic logic [SEG_W-1:0] segments_for(input int digit);
		case (digit)
			0: return 7'b1000000;
			1: return 7'b1111001;
			2: return 7'b0100100;
			3: return 7'b0110000;
			4: return 7'b0011001;
			5: return 7'b0010010;
			6: return 7'b0000010;
			7: return 7'b1111000;
			8: return 7'b0000000;
			default: return 7'b0011000;
		endcase
	endfunction

	// Q16 line fit, clamped at zero, truncated toward zero
	function automatic logic [TEMP_W-1:0] tenths_of(input logic [SAMPLE_W-1:0] raw);
		longint diff;
		longint whole;
		diff = longint'(K_OFFSET) - longint'(K_SLOPE) * longint'(raw);
		if (diff <= 0)
			return '0;
		whole = diff >>> Q_SHIFT;
		return whole[TEMP_W-1:0];
	endfunction

	// advance the state copy by one input beat and form its display beat
	task automatic apply_item(input logic is_sample, input logic [SAMPLE_W-1:0] raw,
			output display_beat_t beat);
		logic [TPD_W-1:0] limit;
		logic [TPD_W-1:0] next_count;
		int value;
		int digit;
		if (is_sample) begin
			stored_temp = tenths_of(raw);
		end else begin
			limit = (dwell_limit == '0) ? TPD_W'(1) : dwell_limit;
			next_count = dwell_ticks + 1'b1;
			if (next_count >= limit || next_count == '0) begin
				dwell_ticks = '0;
				lit_pos = (lit_pos == POS_TENS) ? POS_TENTHS : lit_pos + 1'b1;
			end else begin
				dwell_ticks = next_count;
			end
		end
		value = stored_temp % TEMP_MOD;
		case (lit_pos)
			POS_UNITS: digit = (value / 10) % 10;
			POS_TENS:  digit = (value / 100) % 10;
			default:   digit = value % 10;
		endcase
		beat.seg    = segments_for(digit);
		beat.enable = EN_W'(1) << lit_pos;
		beat.temp   = stored_temp;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < PRINT_CAP)
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// output check first, then the new input beat, then register writes
	always @(posedge clk or negedge arst_n) begin : watch
		display_beat_t got;
		display_beat_t want;
		if (!arst_n) begin
			dwell_limit = TPD_W'(4);
			dwell_ticks = '0;
			lit_pos     = POS_TENTHS;
			stored_temp = '0;
			expected_display.delete();
			error_count = 0;
			pending     = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[OUT_RAW_W-1:0];
				if (expected_display.size() == 0) begin
					report_mismatch("unexpected output beat", int'(got), 0);
				end else begin
					want = expected_display.pop_front();
					if (got.seg !== want.seg)
						report_mismatch("segments", got.seg, want.seg);
					if (got.enable !== want.enable)
						report_mismatch("digit_enable", got.enable, want.enable);
					if (got.temp !== want.temp)
						report_mismatch("temperature_tenths", got.temp, want.temp);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_item(carries_sample, s_axis_tdata[SAMPLE_W-1:0], want);
				expected_display.push_back(want);
			end
			if (cfg_we)
				dwell_limit = cfg_wdata;
			pending = expected_display.size();
		end
	end

endmodule

### tb/adc_temperature_seven_segment_display_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_temperature_seven_segment_display_test: stimulus and verdict
// Drives samples and ticks into the display block under several dwell
// settings and three idle patterns on the two streams. A separate checker
// predicts every display beat and counts mismatches.
// ----------------------------------------------------------------------------
module adc_temperature_seven_segment_display_test;
	import adcts_pkg::*;

	localparam logic CMD_TICK     = 1'b0;
	localparam logic CMD_SAMPLE   = 1'b1;
	localparam int   RAND_PHASES  = 7;
	localparam int   PHASE_ITEMS  = 280;
	localparam int   DRAIN_CYCLES = 8;
	localparam int   CYCLE_LIMIT  = 200000;
	// lowest reading that converts to a negative temperature
	localparam logic [SAMPLE_W-1:0] FIRST_NEG = 12'd934;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [TPD_W-1:0]       cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;	// [11:0] sample
	logic                   s_axis_tuser  = 1'b0;	// [0] command
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;	// [6:0] segments, [9:7] digit_enable,
						// [22:10] temperature_tenths
	int unsigned            mismatches;
	int unsigned            outstanding;

	int                     send_idle_pct = 25;
	int                     recv_idle_pct = 47;
	int                     cycle_count   = 0;

	adc_temperature_seven_segment_display i_dut (.*);

	adc_display_checker i_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= IN_TDATA_W'(smp);
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// hold off until every display beat has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_dwell(input logic [TPD_W-1:0] ticks);
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly readings in the positive range, some extremes and negatives
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		if (r < 6)
			return '1;
		if (r < 9)
			return FIRST_NEG - 1'b1;
		if (r < 12)
			return FIRST_NEG;
		if (r < 75)
			return SAMPLE_W'($urandom_range(FIRST_NEG - 1));
		return SAMPLE_W'($urandom);
	endfunction

	initial begin
		logic [TPD_W-1:0] dwell_setting;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes of the conversion, full scan at reset dwell
		send_item(CMD_SAMPLE, '0);
		repeat (4) send_item(CMD_TICK, '0);
		send_item(CMD_SAMPLE, '1);
		send_item(CMD_SAMPLE, FIRST_NEG - 1'b1);
		send_item(CMD_SAMPLE, FIRST_NEG);
		send_item(CMD_SAMPLE, 12'hAAA);
		send_item(CMD_SAMPLE, 12'h555);
		send_item(CMD_SAMPLE, 12'd1);
		repeat (8) send_item(CMD_TICK, '0);

		// longest dwell, then lowered below the running count
		wait_drained();
		write_dwell('1);
		send_item(CMD_SAMPLE, 12'd500);
		repeat (4) send_item(CMD_TICK, '0);
		wait_drained();
		write_dwell(TPD_W'(2));
		send_item(CMD_TICK, '0);

		// random phases over several dwell settings
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: dwell_setting = TPD_W'(1);
				1: dwell_setting = '0;
				2: dwell_setting = TPD_W'(2);
				3: dwell_setting = '1;
				4: dwell_setting = TPD_W'(3);
				5: dwell_setting = TPD_W'(9);
				default: dwell_setting = TPD_W'($urandom_range(20, 4));
			endcase
			case (phase * 3 / RAND_PHASES)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			wait_drained();
			write_dwell(dwell_setting);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender pause mid-phase until everything is back
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				if ($urandom_range(99) < 65)
					send_item(CMD_TICK, SAMPLE_W'($urandom));
				else
					send_item(CMD_SAMPLE, pick_sample());
			end
		end

		wait_drained();
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### adc_temperature_seven_segment_display.f
src/adcts_pkg.sv
src/adcts_conv.sv
src/adcts_digits.sv
src/adc_temperature_seven_segment_display.sv
tb/adc_display_checker.sv
tb/adc_temperature_seven_segment_display_test.sv
